/* sv/sti_pkg.sv */
`timescale 1ns / 1ps
package sti_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_EMPTY   = 2'd1;
   localparam logic [1:0] STS_DIM_ERR = 2'd2;
   localparam logic [1:0] STS_FULL    = 2'd3;

   localparam logic [1:0] REG_DIM    = 2'd0;
   localparam logic [1:0] REG_INTERP = 2'd1;
   localparam logic [1:0] REG_EXTRAP = 2'd2;
   localparam logic [1:0] REG_TOL    = 2'd3;

   // 33 bits of |dt| with 16 bits of fraction shifted in below them in the dividend
   localparam int DIV_STEPS = 49;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_TOL, S_PREV_RD, S_PREV_CHK, S_DIV,
      S_ROW_RD, S_ROW_EMIT, S_LIN_RDA, S_LIN_RDB, S_LIN_DIFF, S_LIN_MUL_LO,
      S_LIN_MUL_HI, S_LIN_EMIT
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE, EMIT_OP, EMIT_EMPTY, EMIT_ROW, EMIT_LIN
   } emit_type;

   typedef enum logic [1:0] {
      VS_ROW, VS_PREV, VS_CUR
   } vsel_type;

   typedef struct packed {
      logic     load;
      logic     exec_op;
      logic     i_clr;
      logic     i_inc;
      logic     t_rd_prev;
      logic     latch_ti;
      logic     set_row;
      logic     row_prev;
      vsel_type v_sel;
      logic     e_clr;
      logic     e_inc;
      logic     div_start;
      logic     div_step;
      logic     latch_a;
      logic     latch_d;
      logic     mul_lo;
      logic     mul_hi;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       count_zero;
      logic       time_lt;
      logic       past_last;
      logic       tol_hit;
      logic       i_zero;
      logic       interp;
      logic       extrap;
      logic       span_zero;
      logic       div_done;
      logic       e_last;
   } stat_type;

endpackage

/* sv/sti_ram.sv */
`timescale 1ns / 1ps
module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/sti_ctrl.sv */
`timescale 1ns / 1ps
module sti_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sti_pkg::stat_type st,
   output sti_pkg::cmd_type  cmd
);
   sti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sti_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != sti_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sti_pkg::S_IDLE: begin
            if (start) state_in = sti_pkg::S_DECODE;
         end
         sti_pkg::S_DECODE: begin
            if (st.opcode == sti_pkg::OP_QUERY && !st.count_zero)
               state_in = sti_pkg::S_SCAN_RD;
            else
               state_in = sti_pkg::S_IDLE;
         end
         sti_pkg::S_SCAN_RD: state_in = sti_pkg::S_SCAN_CHK;
         sti_pkg::S_SCAN_CHK: begin
            if (!st.time_lt) state_in = sti_pkg::S_TOL;
            else if (!st.past_last) state_in = sti_pkg::S_SCAN_RD;
            else if (st.extrap) state_in = sti_pkg::S_ROW_RD;
            else state_in = sti_pkg::S_TOL;
         end
         sti_pkg::S_TOL: begin
            if (st.tol_hit || st.i_zero || !st.interp) state_in = sti_pkg::S_ROW_RD;
            else state_in = sti_pkg::S_PREV_RD;
         end
         sti_pkg::S_PREV_RD: state_in = sti_pkg::S_PREV_CHK;
         sti_pkg::S_PREV_CHK: begin
            if (st.span_zero) state_in = sti_pkg::S_ROW_RD;
            else state_in = sti_pkg::S_DIV;
         end
         sti_pkg::S_DIV: begin
            if (st.div_done) state_in = sti_pkg::S_LIN_RDA;
         end
         sti_pkg::S_ROW_RD: state_in = sti_pkg::S_ROW_EMIT;
         sti_pkg::S_ROW_EMIT: begin
            if (st.e_last) state_in = sti_pkg::S_IDLE;
            else state_in = sti_pkg::S_ROW_RD;
         end
         sti_pkg::S_LIN_RDA: state_in = sti_pkg::S_LIN_RDB;
         sti_pkg::S_LIN_RDB: state_in = sti_pkg::S_LIN_DIFF;
         sti_pkg::S_LIN_DIFF: state_in = sti_pkg::S_LIN_MUL_LO;
         sti_pkg::S_LIN_MUL_LO: state_in = sti_pkg::S_LIN_MUL_HI;
         sti_pkg::S_LIN_MUL_HI: state_in = sti_pkg::S_LIN_EMIT;
         sti_pkg::S_LIN_EMIT: begin
            if (st.e_last) state_in = sti_pkg::S_IDLE;
            else state_in = sti_pkg::S_LIN_RDA;
         end
         default: state_in = sti_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.v_sel = sti_pkg::VS_ROW;
      cmd.emit = sti_pkg::EMIT_NONE;
      case (state_ff)
         sti_pkg::S_IDLE: cmd.load = start;
         sti_pkg::S_DECODE: begin
            cmd.exec_op = 1'b1;
            cmd.e_clr = 1'b1;
            cmd.i_clr = 1'b1;
            if (st.opcode == sti_pkg::OP_CLEAR || st.opcode == sti_pkg::OP_APPEND)
               cmd.emit = sti_pkg::EMIT_OP;
            else if (st.opcode == sti_pkg::OP_QUERY && st.count_zero)
               cmd.emit = sti_pkg::EMIT_EMPTY;
         end
         sti_pkg::S_SCAN_CHK: begin
            cmd.latch_ti = 1'b1;
            if (st.time_lt && !st.past_last) cmd.i_inc = 1'b1;
            if (st.time_lt && st.past_last && st.extrap) cmd.set_row = 1'b1;
         end
         sti_pkg::S_TOL: begin
            if (st.tol_hit || st.i_zero) begin
               cmd.set_row = 1'b1;
            end else if (!st.interp) begin
               cmd.set_row = 1'b1;
               cmd.row_prev = 1'b1;
            end
         end
         sti_pkg::S_PREV_RD: cmd.t_rd_prev = 1'b1;
         sti_pkg::S_PREV_CHK: begin
            if (st.span_zero) begin
               cmd.set_row = 1'b1;
               cmd.row_prev = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         sti_pkg::S_DIV: cmd.div_step = !st.div_done;
         sti_pkg::S_ROW_EMIT: begin
            cmd.emit = sti_pkg::EMIT_ROW;
            cmd.e_inc = 1'b1;
         end
         sti_pkg::S_LIN_RDA: cmd.v_sel = sti_pkg::VS_PREV;
         sti_pkg::S_LIN_RDB: begin
            cmd.latch_a = 1'b1;
            cmd.v_sel = sti_pkg::VS_CUR;
         end
         sti_pkg::S_LIN_DIFF: cmd.latch_d = 1'b1;
         sti_pkg::S_LIN_MUL_LO: cmd.mul_lo = 1'b1;
         sti_pkg::S_LIN_MUL_HI: cmd.mul_hi = 1'b1;
         sti_pkg::S_LIN_EMIT: begin
            cmd.emit = sti_pkg::EMIT_LIN;
            cmd.e_inc = 1'b1;
         end
         default: cmd.load = 1'b0;
      endcase
   end
endmodule

/* sv/sti_dp.sv */
`timescale 1ns / 1ps
module sti_dp #(
   parameter int MAX_SAMPLES = 256,
   parameter int MAX_DIM = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  sti_pkg::cmd_type    cmd,
   output sti_pkg::stat_type   st,
   input  logic                tbl_clear,
   input  logic [3:0]          cfg_dim,
   input  logic                cfg_interp,
   input  logic                cfg_extrap,
   input  logic [30:0]         cfg_tol,
   input  logic [1:0]          req_opcode,
   input  logic signed [31:0]  req_sample_time,
   input  logic signed [31:0]  req_element_value,
   input  logic                req_end_of_sample,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_value_out,
   output logic [2:0]          rsp_element_number,
   output logic                rsp_last_result
);
   localparam int RW  = $clog2(MAX_SAMPLES);
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int EW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DCW = $clog2(MAX_DIM + 2);
   localparam int VD  = MAX_SAMPLES * MAX_DIM;
   localparam int VAW = $clog2(VD);

   // latched item
   logic [1:0]         op_ff;
   logic signed [31:0] q_ff, val_ff;
   logic               eos_ff;

   // table bookkeeping
   logic [CW-1:0]      count_ff;
   logic [DCW-1:0]     pend_ff;
   logic [31:0]        ptime_ff;

   // query state
   logic [RW-1:0]      i_ff;
   logic [EW-1:0]      e_ff;
   logic               row_prev_ff;
   logic signed [31:0] ti_ff, a_ff;
   logic [48:0]        div_n_ff;
   logic [32:0]        div_d_ff, rem_ff;
   logic               frac_neg_ff;
   logic [5:0]         div_cnt_ff;
   logic [32:0]        dmag_ff;
   logic               d_neg_ff;
   logic [63:0]        acc_ff;

   logic               strobe_ff;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        value_ff, value_in;
   logic [2:0]         elem_ff, elem_in;
   logic               last_ff, last_in;

   // memories
   logic               t_we, v_we;
   logic [RW-1:0]      t_waddr, t_raddr;
   logic [31:0]        t_rdata, v_rdata;
   logic [VAW-1:0]     v_waddr, v_raddr;
   logic [31:0]        pt;

   sti_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_time (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(pt),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   sti_ram #(.WIDTH(32), .DEPTH(VD)) u_value (
      .clock(clock), .we(v_we), .waddr(v_waddr), .wdata(val_ff),
      .raddr(v_raddr), .rdata(v_rdata)
   );

   // effective dimension
   logic [DCW-1:0] dim_eff;
   always_comb begin
      if (cfg_dim == 4'd0) dim_eff = DCW'(1);
      else if (int'(cfg_dim) > MAX_DIM) dim_eff = DCW'(MAX_DIM);
      else dim_eff = DCW'(cfg_dim);
   end

   // append
   logic           full, is_append, is_clear;
   logic [DCW-1:0] pend_inc;
   logic [1:0]     app_status;

   assign full      = count_ff >= CW'(MAX_SAMPLES);
   assign is_append = cmd.exec_op && op_ff == sti_pkg::OP_APPEND;
   assign is_clear  = cmd.exec_op && op_ff == sti_pkg::OP_CLEAR;
   assign pt        = (pend_ff == '0) ? q_ff : ptime_ff;
   assign pend_inc  = (pend_ff < DCW'(MAX_DIM + 1)) ? pend_ff + DCW'(1) : pend_ff;

   always_comb begin
      app_status = sti_pkg::STS_OK;
      if (eos_ff) begin
         if (full) app_status = sti_pkg::STS_FULL;
         else if (pend_inc != dim_eff) app_status = sti_pkg::STS_DIM_ERR;
      end
   end

   assign v_we    = is_append && !full && pend_ff < dim_eff;
   assign v_waddr = VAW'(int'(count_ff[RW-1:0]) * MAX_DIM + int'(pend_ff));
   assign t_we    = is_append && eos_ff && !full && pend_inc == dim_eff;
   assign t_waddr = count_ff[RW-1:0];

   // read addresses
   logic [RW-1:0] i_prev, row_idx;
   assign i_prev  = i_ff - RW'(1);
   assign t_raddr = cmd.t_rd_prev ? i_prev : i_ff;
   always_comb begin
      case (cmd.v_sel)
         sti_pkg::VS_PREV: row_idx = i_prev;
         sti_pkg::VS_CUR:  row_idx = i_ff;
         default:          row_idx = row_prev_ff ? i_prev : i_ff;
      endcase
   end
   assign v_raddr = VAW'(int'(row_idx) * MAX_DIM + int'(e_ff));

   // compares
   logic [32:0] qdiff, qdiff_mag, dt, span, dt_mag, span_mag;
   assign qdiff     = {q_ff[31], q_ff} - {ti_ff[31], ti_ff};
   assign qdiff_mag = qdiff[32] ? -qdiff : qdiff;
   assign dt        = {q_ff[31], q_ff} - {t_rdata[31], t_rdata};
   assign span      = {ti_ff[31], ti_ff} - {t_rdata[31], t_rdata};
   assign dt_mag    = dt[32] ? -dt : dt;
   assign span_mag  = span[32] ? -span : span;

   logic e_last;
   assign e_last = (DCW'(e_ff) + DCW'(1)) == dim_eff;

   always_comb begin
      st.opcode     = op_ff;
      st.count_zero = count_ff == '0;
      st.time_lt    = $signed(t_rdata) < q_ff;
      st.past_last  = (CW'(i_ff) + CW'(1)) == count_ff;
      st.tol_hit    = qdiff_mag < {2'b00, cfg_tol};
      st.i_zero     = i_ff == '0;
      st.interp     = cfg_interp;
      st.extrap     = cfg_extrap;
      st.span_zero  = span == '0;
      st.div_done   = div_cnt_ff == '0;
      st.e_last     = e_last;
   end

   // divider step
   logic [33:0] rem2;
   logic        q_bit;
   assign rem2  = {rem_ff, div_n_ff[48]};
   assign q_bit = rem2 >= {1'b0, div_d_ff};

   // saturated fraction magnitude
   logic [31:0] fmag;
   assign fmag = (div_n_ff > 49'h0_8000_0000) ? 32'h8000_0000 : div_n_ff[31:0];

   // multiplier
   logic [15:0] m_op;
   logic [48:0] prod;
   assign m_op = cmd.mul_hi ? fmag[31:16] : fmag[15:0];
   assign prod = dmag_ff * m_op;

   // linear result
   logic [32:0]        d_full;
   logic [47:0]        delta;
   logic signed [49:0] lin_sum;
   logic [31:0]        lin_sat;
   assign d_full = {v_rdata[31], v_rdata} - {a_ff[31], a_ff};
   assign delta  = acc_ff[63:16];
   always_comb begin
      if (d_neg_ff ^ frac_neg_ff)
         lin_sum = {{18{a_ff[31]}}, a_ff} - $signed({2'b00, delta});
      else
         lin_sum = {{18{a_ff[31]}}, a_ff} + $signed({2'b00, delta});
      if (lin_sum > 50'sh0_0000_7FFF_FFFF) lin_sat = 32'h7FFF_FFFF;
      else if (lin_sum < -50'sh0_0000_8000_0000) lin_sat = 32'h8000_0000;
      else lin_sat = lin_sum[31:0];
   end

   // next result beat
   always_comb begin
      status_in = sti_pkg::STS_OK;
      value_in  = '0;
      elem_in   = '0;
      last_in   = 1'b1;
      case (cmd.emit)
         sti_pkg::EMIT_OP: begin
            if (op_ff == sti_pkg::OP_APPEND) status_in = app_status;
         end
         sti_pkg::EMIT_EMPTY: status_in = sti_pkg::STS_EMPTY;
         sti_pkg::EMIT_ROW: begin
            value_in = v_rdata;
            elem_in  = 3'(e_ff);
            last_in  = e_last;
         end
         sti_pkg::EMIT_LIN: begin
            value_in = lin_sat;
            elem_in  = 3'(e_ff);
            last_in  = e_last;
         end
         default: last_in = 1'b1;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= '0;
         ptime_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit != sti_pkg::EMIT_NONE;
         if (tbl_clear || is_clear) begin
            count_ff <= '0;
            pend_ff  <= '0;
            ptime_ff <= '0;
         end else if (is_append) begin
            ptime_ff <= pt;
            pend_ff  <= eos_ff ? '0 : pend_inc;
            if (t_we) count_ff <= count_ff + CW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         q_ff   <= req_sample_time;
         val_ff <= req_element_value;
         eos_ff <= req_end_of_sample;
      end
      if (cmd.i_clr) i_ff <= '0;
      else if (cmd.i_inc) i_ff <= i_ff + RW'(1);
      if (cmd.e_clr) e_ff <= '0;
      else if (cmd.e_inc) e_ff <= e_ff + EW'(1);
      if (cmd.set_row) row_prev_ff <= cmd.row_prev;
      if (cmd.latch_ti) ti_ff <= t_rdata;
      if (cmd.div_start) begin
         div_n_ff    <= {dt_mag, 16'h0000};
         div_d_ff    <= span_mag;
         rem_ff      <= '0;
         frac_neg_ff <= dt[32] ^ span[32];
         div_cnt_ff  <= 6'(sti_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_ff     <= q_bit ? 33'(rem2 - {1'b0, div_d_ff}) : rem2[32:0];
         div_n_ff   <= {div_n_ff[47:0], q_bit};
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
      if (cmd.latch_a) a_ff <= v_rdata;
      if (cmd.latch_d) begin
         d_neg_ff <= d_full[32];
         dmag_ff  <= d_full[32] ? -d_full : d_full;
      end
      if (cmd.mul_lo) acc_ff <= 64'(prod);
      else if (cmd.mul_hi) acc_ff <= acc_ff + (64'(prod) << 16);

      status_ff <= status_in;
      value_ff  <= value_in;
      elem_ff   <= elem_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_value_out      = value_ff;
   assign rsp_element_number = elem_ff;
   assign rsp_last_result    = last_ff;
endmodule

/* sv/sampled_table_interpolator.sv */
`timescale 1ns / 1ps
// Table of time-stamped Q16.16 sample vectors with time queries. Start an
// item with start while busy is low; each result beat sits on the rsp_ ports
// for exactly one cycle under rsp_strobe and cannot be stalled, so capture it
// there. Clear and append give one beat. A query on an empty table gives one
// beat. Any other query scans the stored times in order through the time
// memory's read port until one is not below the query time or the last entry
// is reached, then does the tolerance check (skipped when extrapolating past
// the last entry), and, for linear interpolation, reads the left time and runs
// the bit-serial fraction divider (49 shift steps and a final done check); it
// then emits one beat per element, either from a stored row or interpolated
// (two value memory reads and a 33x16 multiplier used twice).
// Writing a different vector_dimension empties the table.
module sampled_table_interpolator #(
   parameter int MAX_SAMPLES = 256,
   parameter int MAX_DIM = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_sample_time,
   input  logic signed [31:0] req_element_value,
   input  logic               req_end_of_sample,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [2:0]         rsp_element_number,
   output logic               rsp_last_result,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   // configuration registers
   logic [3:0]  dim_ff;
   logic        interp_ff, extrap_ff;
   logic [30:0] tol_ff;
   logic        wr_beat, tbl_clear;

   sti_pkg::cmd_type  cmd;
   sti_pkg::stat_type st;

   assign pready    = 1'b1;
   assign wr_beat   = psel && penable && pwrite;
   // a changed dimension invalidates every stored row
   assign tbl_clear = wr_beat && paddr[3:2] == sti_pkg::REG_DIM && pwdata[3:0] != dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= 4'd1;
         interp_ff <= 1'b1;
         extrap_ff <= 1'b1;
         tol_ff    <= '0;
      end else if (wr_beat) begin
         case (paddr[3:2])
            sti_pkg::REG_DIM:    dim_ff    <= pwdata[3:0];
            sti_pkg::REG_INTERP: interp_ff <= pwdata[0];
            sti_pkg::REG_EXTRAP: extrap_ff <= pwdata[0];
            sti_pkg::REG_TOL:    tol_ff    <= pwdata[30:0];
            default:             tol_ff    <= tol_ff;
         endcase
      end
   end

   // read back
   always_comb begin
      case (paddr[3:2])
         sti_pkg::REG_DIM:    prdata = {28'd0, dim_ff};
         sti_pkg::REG_INTERP: prdata = {31'd0, interp_ff};
         sti_pkg::REG_EXTRAP: prdata = {31'd0, extrap_ff};
         sti_pkg::REG_TOL:    prdata = {1'b0, tol_ff};
         default:             prdata = '0;
      endcase
   end

   // sequencer: decodes the item and walks scan, divide and element loops
   sti_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .st(st), .cmd(cmd)
   );

   // datapath: table memories, divider, multiplier and result beat register
   sti_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_DIM(MAX_DIM)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st), .tbl_clear(tbl_clear),
      .cfg_dim(dim_ff), .cfg_interp(interp_ff), .cfg_extrap(extrap_ff),
      .cfg_tol(tol_ff),
      .req_opcode(req_opcode), .req_sample_time(req_sample_time),
      .req_element_value(req_element_value), .req_end_of_sample(req_end_of_sample),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_element_number(rsp_element_number), .rsp_last_result(rsp_last_result)
   );
endmodule
